>>> rtl/bdll_pkg.sv
// Package: sizes, command and status codes, word types and sequencer states for the list core.
`default_nettype none
package bdll_pkg;

  localparam int CAPACITY    = 16;
  localparam int VALUE_WIDTH = 32;
  localparam int SLOT_W      = $clog2(CAPACITY);
  localparam int CNT_W       = $clog2(CAPACITY + 1);

  localparam logic [3:0] OP_PUSH_HEAD   = 4'd0;
  localparam logic [3:0] OP_PUSH_TAIL   = 4'd1;
  localparam logic [3:0] OP_POP_HEAD    = 4'd2;
  localparam logic [3:0] OP_POP_TAIL    = 4'd3;
  localparam logic [3:0] OP_INSERT_NEXT = 4'd4;
  localparam logic [3:0] OP_ERASE       = 4'd5;
  localparam logic [3:0] OP_REVERSE     = 4'd6;
  localparam logic [3:0] OP_CLEAR       = 4'd7;
  localparam logic [3:0] OP_QUERY       = 4'd8;

  localparam logic [1:0] STAT_OK    = 2'd0;
  localparam logic [1:0] STAT_EMPTY = 2'd1;
  localparam logic [1:0] STAT_RANGE = 2'd2;
  localparam logic [1:0] STAT_FULL  = 2'd3;

  typedef struct packed {
    logic [3:0]  op;
    logic [31:0] value;
    logic [3:0]  position;
  } cmd_t;

  typedef struct packed {
    logic [31:0] front_value;
    logic [31:0] back_value;
    logic [4:0]  count;
    logic [1:0]  status;
  } rsp_t;

  // control into the free slot map
  typedef struct packed {
    logic              take;
    logic              drop;
    logic              clear;
    logic [SLOT_W-1:0] drop_slot;
  } free_ctl_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_POP_F,
    S_POP_B,
    S_WALK,
    S_LINK_RD,
    S_INS_A,
    S_INS_B,
    S_ERS,
    S_REV,
    S_FETCH,
    S_DONE
  } state_t;

endpackage
`default_nettype wire

>>> rtl/bdll_free_map.sv
// Free slot map: one bit per slot, lowest free slot search, take / drop / clear.
`default_nettype none
module bdll_free_map (
  input  wire                        clk,
  input  wire                        rst_n,
  input  bdll_pkg::free_ctl_t        ctl,
  output logic [bdll_pkg::SLOT_W-1:0] low_slot
);
  import bdll_pkg::*;

  logic [CAPACITY-1:0] free_r;
  logic [CAPACITY-1:0] free_nxt;

  // lowest set bit wins
  always_comb begin
    low_slot = '0;
    for (int i = CAPACITY - 1; i >= 0; i--) begin
      if (free_r[i]) begin
        low_slot = SLOT_W'(i);
      end
    end
  end

  always_comb begin
    free_nxt = free_r;
    if (ctl.clear) begin
      free_nxt = '1;
    end else if (ctl.take) begin
      free_nxt[low_slot] = 1'b0;
    end else if (ctl.drop) begin
      free_nxt[ctl.drop_slot] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      free_r <= '1;
    end else begin
      free_r <= free_nxt;
    end
  end

endmodule
`default_nettype wire

>>> rtl/bounded_doubly_linked_list_core.sv
// Top level: bounded doubly linked list with slot pool, link memories and command sequencer.
// Sequence: DECODE, then POP_F / POP_B (pop with two or more held), WALK (p > 0) and LINK_RD
//   then INS_A, INS_B or ERS (insert / erase at p), or REV per element (reverse), then FETCH, DONE.
// Throughput: one command at a time; in_ready is high only while the sequencer idles, from the
//   cycle the word appears; a word the receiver has not taken holds the next one in DONE.
// Reset: sync, active low; list empty, all slots free, no word pending; memories not cleared.
`default_nettype none
module bounded_doubly_linked_list_core (
  input  wire            clk,
  input  wire            rst_n,
  input  wire            in_valid,
  output logic           in_ready,
  input  bdll_pkg::cmd_t in_data,
  output logic           out_valid,
  input  wire            out_ready,
  output bdll_pkg::rsp_t out_data
);
  import bdll_pkg::*;

  // sequencer
  state_t state_r, state_nxt;

  // latched command word
  logic [3:0]             op_r, op_nxt;
  logic [VALUE_WIDTH-1:0] val_r, val_nxt;
  logic [3:0]             pos_r, pos_nxt;

  // list control state
  logic [SLOT_W-1:0] head_r, head_nxt;
  logic [SLOT_W-1:0] tail_r, tail_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;

  // working registers
  logic [SLOT_W-1:0] cur_r, cur_nxt;     // node under the walk
  logic [3:0]        idx_r, idx_nxt;     // walk / reverse step count
  logic [SLOT_W-1:0] new_r, new_nxt;     // slot taken by insert
  logic [SLOT_W-1:0] nx_r, nx_nxt;       // successor of cur on insert
  logic              at_tail_r, at_tail_nxt;
  logic [1:0]        status_r, status_nxt;

  // result word register
  rsp_t out_data_r;
  logic out_valid_r;
  logic out_load;

  // memories
  logic [VALUE_WIDTH-1:0] val_mem [CAPACITY];
  logic [SLOT_W-1:0]      nxt_mem [CAPACITY];
  logic [SLOT_W-1:0]      prv_mem [CAPACITY];

  logic                   val_we;
  logic [SLOT_W-1:0]      val_wa;
  logic [VALUE_WIDTH-1:0] val_rd0_r, val_rd1_r;

  logic              nxt_we, prv_we;
  logic [SLOT_W-1:0] nxt_wa, nxt_wd, nxt_ra, nxt_rd_r;
  logic [SLOT_W-1:0] prv_wa, prv_wd, prv_ra, prv_rd_r;

  // free slot map
  free_ctl_t         fm_ctl;
  logic [SLOT_W-1:0] free_slot;

  bdll_free_map u_free_map (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl      (fm_ctl),
    .low_slot (free_slot)
  );

  // decode flags
  logic is_full, is_empty, pos_bad, one_left, walk_hit, rev_last;

  assign is_full  = (count_r == CNT_W'(CAPACITY));
  assign is_empty = (count_r == '0);
  assign one_left = (count_r == CNT_W'(1));
  assign pos_bad  = ({1'b0, pos_r} >= count_r);
  assign walk_hit = (idx_r == pos_r);
  assign rev_last = ((CNT_W'(idx_r) + CNT_W'(1)) == count_r);

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign out_load  = (state_r == S_DONE) && (!out_valid_r || out_ready);

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) state_nxt = S_DECODE;
      end
      S_DECODE: begin
        state_nxt = S_FETCH;
        case (op_r)
          OP_POP_HEAD: begin
            if (!is_empty && !one_left) state_nxt = S_POP_F;
          end
          OP_POP_TAIL: begin
            if (!is_empty && !one_left) state_nxt = S_POP_B;
          end
          OP_INSERT_NEXT: begin
            if (!pos_bad && !is_full) state_nxt = (pos_r == '0) ? S_LINK_RD : S_WALK;
          end
          OP_ERASE: begin
            if (!pos_bad) state_nxt = (pos_r == '0) ? S_LINK_RD : S_WALK;
          end
          OP_REVERSE: begin
            if (!is_empty) state_nxt = S_REV;
          end
          default: state_nxt = S_FETCH;
        endcase
      end
      S_POP_F:   state_nxt = S_FETCH;
      S_POP_B:   state_nxt = S_FETCH;
      S_WALK: begin
        if (walk_hit) state_nxt = S_LINK_RD;
      end
      S_LINK_RD: state_nxt = (op_r == OP_INSERT_NEXT) ? S_INS_A : S_ERS;
      S_INS_A:   state_nxt = S_INS_B;
      S_INS_B:   state_nxt = S_FETCH;
      S_ERS:     state_nxt = S_FETCH;
      S_REV: begin
        if (rev_last) state_nxt = S_FETCH;
      end
      S_FETCH:   state_nxt = S_DONE;
      S_DONE: begin
        if (out_load) state_nxt = S_IDLE;
      end
      default:   state_nxt = S_IDLE;
    endcase
  end

  // datapath and memory controls
  always_comb begin
    op_nxt      = op_r;
    val_nxt     = val_r;
    pos_nxt     = pos_r;
    head_nxt    = head_r;
    tail_nxt    = tail_r;
    count_nxt   = count_r;
    cur_nxt     = cur_r;
    idx_nxt     = idx_r;
    new_nxt     = new_r;
    nx_nxt      = nx_r;
    at_tail_nxt = at_tail_r;
    status_nxt  = status_r;

    val_we = 1'b0;
    val_wa = free_slot;
    nxt_we = 1'b0;
    nxt_wa = cur_r;
    nxt_wd = cur_r;
    nxt_ra = cur_r;
    prv_we = 1'b0;
    prv_wa = cur_r;
    prv_wd = cur_r;
    prv_ra = cur_r;

    fm_ctl = '0;

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          op_nxt  = in_data.op;
          val_nxt = in_data.value[VALUE_WIDTH-1:0];
          pos_nxt = in_data.position;
        end
      end

      S_DECODE: begin
        status_nxt = STAT_OK;
        case (op_r)
          OP_PUSH_HEAD, OP_PUSH_TAIL: begin
            if (is_full) begin
              status_nxt = STAT_FULL;
            end else begin
              val_we      = 1'b1;
              val_wa      = free_slot;
              fm_ctl.take = 1'b1;
              count_nxt   = count_r + CNT_W'(1);
              if (is_empty) begin
                head_nxt = free_slot;
                tail_nxt = free_slot;
              end else if (op_r == OP_PUSH_HEAD) begin
                nxt_we   = 1'b1;
                nxt_wa   = free_slot;
                nxt_wd   = head_r;
                prv_we   = 1'b1;
                prv_wa   = head_r;
                prv_wd   = free_slot;
                head_nxt = free_slot;
              end else begin
                prv_we   = 1'b1;
                prv_wa   = free_slot;
                prv_wd   = tail_r;
                nxt_we   = 1'b1;
                nxt_wa   = tail_r;
                nxt_wd   = free_slot;
                tail_nxt = free_slot;
              end
            end
          end
          OP_POP_HEAD, OP_POP_TAIL: begin
            if (is_empty) begin
              status_nxt = STAT_EMPTY;
            end else if (one_left) begin
              // last element leaves: list collapses to slot 0
              fm_ctl.drop      = 1'b1;
              fm_ctl.drop_slot = head_r;
              count_nxt        = '0;
              head_nxt         = '0;
              tail_nxt         = '0;
            end else begin
              nxt_ra = head_r;
              prv_ra = tail_r;
            end
          end
          OP_INSERT_NEXT, OP_ERASE: begin
            if (pos_bad) begin
              status_nxt = STAT_RANGE;
            end else if (is_full && (op_r == OP_INSERT_NEXT)) begin
              status_nxt = STAT_FULL;
            end else begin
              cur_nxt = head_r;
              nxt_ra  = head_r;
              idx_nxt = 4'd1;
            end
          end
          OP_REVERSE: begin
            if (is_empty) begin
              head_nxt = tail_r;
              tail_nxt = head_r;
            end else begin
              cur_nxt = head_r;
              idx_nxt = '0;
              nxt_ra  = head_r;
              prv_ra  = head_r;
            end
          end
          OP_CLEAR: begin
            fm_ctl.clear = 1'b1;
            head_nxt     = '0;
            tail_nxt     = '0;
            count_nxt    = '0;
          end
          default: begin
          end
        endcase
      end

      S_POP_F: begin
        head_nxt         = nxt_rd_r;
        fm_ctl.drop      = 1'b1;
        fm_ctl.drop_slot = head_r;
        count_nxt        = count_r - CNT_W'(1);
      end

      S_POP_B: begin
        tail_nxt         = prv_rd_r;
        fm_ctl.drop      = 1'b1;
        fm_ctl.drop_slot = tail_r;
        count_nxt        = count_r - CNT_W'(1);
      end

      // one next pointer per cycle, address straight from the read register
      S_WALK: begin
        if (walk_hit) begin
          cur_nxt = nxt_rd_r;
        end else begin
          nxt_ra  = nxt_rd_r;
          idx_nxt = idx_r + 4'd1;
        end
      end

      S_LINK_RD: begin
        nxt_ra = cur_r;
        prv_ra = cur_r;
      end

      S_INS_A: begin
        new_nxt     = free_slot;
        nx_nxt      = nxt_rd_r;
        at_tail_nxt = (cur_r == tail_r);
        fm_ctl.take = 1'b1;
        val_we      = 1'b1;
        val_wa      = free_slot;
        prv_we      = 1'b1;
        prv_wa      = free_slot;
        prv_wd      = cur_r;
        count_nxt   = count_r + CNT_W'(1);
        if (cur_r == tail_r) begin
          tail_nxt = free_slot;
        end else begin
          nxt_we = 1'b1;
          nxt_wa = free_slot;
          nxt_wd = nxt_rd_r;
        end
      end

      S_INS_B: begin
        nxt_we = 1'b1;
        nxt_wa = cur_r;
        nxt_wd = new_r;
        if (!at_tail_r) begin
          prv_we = 1'b1;
          prv_wa = nx_r;
          prv_wd = new_r;
        end
      end

      S_ERS: begin
        fm_ctl.drop      = 1'b1;
        fm_ctl.drop_slot = cur_r;
        count_nxt        = count_r - CNT_W'(1);
        if (one_left) begin
          head_nxt = '0;
          tail_nxt = '0;
        end else if (cur_r == head_r) begin
          head_nxt = nxt_rd_r;
        end else if (cur_r == tail_r) begin
          tail_nxt = prv_rd_r;
        end else begin
          // unlink a middle node
          nxt_we = 1'b1;
          nxt_wa = prv_rd_r;
          nxt_wd = nxt_rd_r;
          prv_we = 1'b1;
          prv_wa = nxt_rd_r;
          prv_wd = prv_rd_r;
        end
      end

      // swap links of cur while fetching the links of its old successor
      S_REV: begin
        nxt_we  = 1'b1;
        nxt_wa  = cur_r;
        nxt_wd  = prv_rd_r;
        prv_we  = 1'b1;
        prv_wa  = cur_r;
        prv_wd  = nxt_rd_r;
        cur_nxt = nxt_rd_r;
        idx_nxt = idx_r + 4'd1;
        if (rev_last) begin
          head_nxt = tail_r;
          tail_nxt = head_r;
        end else begin
          nxt_ra = nxt_rd_r;
          prv_ra = nxt_rd_r;
        end
      end

      default: begin
      end
    endcase
  end

  // memories: value store has two read ports for front and back
  always_ff @(posedge clk) begin
    if (val_we) val_mem[val_wa] <= val_r;
    val_rd0_r <= val_mem[head_r];
    val_rd1_r <= val_mem[tail_r];
  end

  always_ff @(posedge clk) begin
    if (nxt_we) nxt_mem[nxt_wa] <= nxt_wd;
    nxt_rd_r <= nxt_mem[nxt_ra];
  end

  always_ff @(posedge clk) begin
    if (prv_we) prv_mem[prv_wa] <= prv_wd;
    prv_rd_r <= prv_mem[prv_ra];
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      head_r      <= '0;
      tail_r      <= '0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      head_r  <= head_nxt;
      tail_r  <= tail_nxt;
      count_r <= count_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    op_r      <= op_nxt;
    val_r     <= val_nxt;
    pos_r     <= pos_nxt;
    cur_r     <= cur_nxt;
    idx_r     <= idx_nxt;
    new_r     <= new_nxt;
    nx_r      <= nx_nxt;
    at_tail_r <= at_tail_nxt;
    status_r  <= status_nxt;
    if (out_load) begin
      out_data_r.front_value <= is_empty ? 32'd0 : 32'(val_rd0_r);
      out_data_r.back_value  <= is_empty ? 32'd0 : 32'(val_rd1_r);
      out_data_r.count       <= 5'(count_r);
      out_data_r.status      <= status_r;
    end
  end

endmodule
`default_nettype wire
